>>> rtl/core/mbet_pkg.sv
// Shared constants, types and codes for the escape-time counter.
`timescale 1ns / 1ps

package mbet_pkg;

    // Fixed-point format and counter width
    localparam int FRAC_BITS    = 28;
    localparam int COUNT_WIDTH  = 16;
    localparam int C_WIDTH      = 32;
    localparam int RADIUS_WIDTH = 31;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(1);

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET   = RADIUS_WIDTH'(536870912);
    localparam logic [COUNT_WIDTH-1:0]  MAX_ITER_RESET = COUNT_WIDTH'(256);

    // Magnitude of a component that can still be inside the radius
    localparam int MAG_W  = RADIUS_WIDTH;
    localparam int PROD_W = 2 * MAG_W;
    localparam int RR_W   = 2 * RADIUS_WIDTH;
    localparam int SUM_W  = PROD_W + 1;

    // Components saturate at +-2^SAT_EXP
    localparam int SAT_EXP = 34;
    localparam int Z_W     = SAT_EXP + 2;

    // Shifted square and cross terms, and the accumulator that adds them to c
    localparam int QW    = PROD_W - FRAC_BITS;
    localparam int QXW   = PROD_W - FRAC_BITS + 1;
    localparam int ACC_W = (QXW + 3 > Z_W + 1) ? QXW + 3 : Z_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [C_WIDTH-1:0] c_imag;
        logic signed [C_WIDTH-1:0] c_real;
    } point_t;

    typedef struct packed {
        logic [RR_W-1:0]        radius_sq;
        logic [COUNT_WIDTH-1:0] max_iter;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_HOLD
    } iter_state_t;

endpackage

>>> rtl/core/mbet_queue.sv
// Two-entry point queue between the front end and the iteration engine.
`timescale 1ns / 1ps

module mbet_queue
    import mbet_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  point_t    push_data,
    input  logic      pop,
    output point_t    pop_data,
    output q_status_t status
);

    point_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_next;
    logic [QFILL_W-1:0]     fill_reg;
    logic [QFILL_W-1:0]     fill_next;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the incoming point
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);

endmodule

>>> rtl/core/mbet_front.sv
// Front end: configuration registers and input acceptance into the queue.
`timescale 1ns / 1ps

module mbet_front
    import mbet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*C_WIDTH-1:0]  s_tdata,   // c_real [31:0], c_imag [63:32]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  q_status_t             q_status,
    output logic                  push,
    output point_t                push_data,
    output cfg_t                  cfg
);

    localparam logic [RR_W-1:0] RADIUS_SQ_RESET = RR_W'(RADIUS_RESET) * RR_W'(RADIUS_RESET);

    logic [RADIUS_WIDTH-1:0] radius_reg;
    logic [RADIUS_WIDTH-1:0] radius_next;
    logic [COUNT_WIDTH-1:0]  max_iter_reg;
    logic [COUNT_WIDTH-1:0]  max_iter_next;
    logic [RR_W-1:0]         radius_sq_reg;
    logic [RR_W-1:0]         radius_sq_next;

    // Decode register writes; unknown indexes drop
    always_comb
    begin
        radius_next    = radius_reg;
        max_iter_next  = max_iter_reg;
        radius_sq_next = RR_W'(radius_reg) * RR_W'(radius_reg);
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RADIUS:   radius_next   = cfg_data[RADIUS_WIDTH-1:0];
                CFG_MAX_ITER: max_iter_next = cfg_data[COUNT_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RESET;
            max_iter_reg  <= MAX_ITER_RESET;
            radius_sq_reg <= RADIUS_SQ_RESET;
        end
        else
        begin
            radius_reg    <= radius_next;
            max_iter_reg  <= max_iter_next;
            radius_sq_reg <= radius_sq_next;
        end
    end

    assign cfg_ready     = 1'b1;
    assign cfg.radius_sq = radius_sq_reg;
    assign cfg.max_iter  = max_iter_reg;

    // Take a transaction whenever the queue has room
    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && !q_status.full;
    assign push_data = s_tdata;

endmodule

>>> rtl/core/mbet_iter.sv
// Back end: z = z^2 + c iteration engine with escape test and result register.
`timescale 1ns / 1ps

module mbet_iter
    import mbet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  q_status_t              q_status,
    output logic                   pop,
    input  point_t                 pop_data,
    input  cfg_t                   cfg,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COUNT_WIDTH-1:0] m_tdata    // iteration_count [15:0]
);

    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(1) << SAT_EXP;
    localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI;
    localparam logic signed [Z_W-1:0]   MAG_MAX = Z_W'((64'd1 << MAG_W) - 64'd1);

    // Clamp a component to +-2^SAT_EXP
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [ACC_W-1:0] v);
        logic signed [Z_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[Z_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[Z_W-1:0];
        else
            r = v[Z_W-1:0];
        return r;
    endfunction

    iter_state_t state_reg;
    iter_state_t state_next;

    // Control
    logic first_reg;
    logic first_next;
    logic big_reg;
    logic big_next;
    logic neg_reg;
    logic neg_next;
    logic out_valid_reg;
    logic out_valid_next;

    // Payload
    logic signed [C_WIDTH-1:0] cr_reg;
    logic signed [C_WIDTH-1:0] cr_next;
    logic signed [C_WIDTH-1:0] ci_reg;
    logic signed [C_WIDTH-1:0] ci_next;
    logic signed [Z_W-1:0]     zr_reg;
    logic signed [Z_W-1:0]     zr_next;
    logic signed [Z_W-1:0]     zi_reg;
    logic signed [Z_W-1:0]     zi_next;
    logic [PROD_W-1:0]         prr_reg;
    logic [PROD_W-1:0]         prr_next;
    logic [PROD_W-1:0]         pii_reg;
    logic [PROD_W-1:0]         pii_next;
    logic [PROD_W-1:0]         pri_reg;
    logic [PROD_W-1:0]         pri_next;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [COUNT_WIDTH-1:0]    count_next;
    logic [COUNT_WIDTH-1:0]    out_count_reg;
    logic [COUNT_WIDTH-1:0]    out_count_next;

    // Datapath intermediates
    logic [Z_W-1:0]            zr_abs;
    logic [Z_W-1:0]            zi_abs;
    logic [MAG_W-1:0]          ar;
    logic [MAG_W-1:0]          ai;
    logic [QW-1:0]             qr;
    logic [QW-1:0]             qi;
    logic [QXW-1:0]            qx;
    logic [ACC_W-1:0]          qx_ext;
    logic signed [ACC_W-1:0]   cross_term;
    logic signed [ACC_W-1:0]   acc_r;
    logic signed [ACC_W-1:0]   acc_i;
    logic signed [Z_W-1:0]     zr_new;
    logic signed [Z_W-1:0]     zi_new;
    logic [SUM_W-1:0]          mag_sq;
    logic                      in_bounds;
    logic                      keep_going;
    logic                      out_free;

    // Magnitudes and the three products of the current z
    always_comb
    begin
        zr_abs   = zr_reg[Z_W-1] ? (~zr_reg + 1'b1) : zr_reg;
        zi_abs   = zi_reg[Z_W-1] ? (~zi_reg + 1'b1) : zi_reg;
        ar       = zr_abs[MAG_W-1:0];
        ai       = zi_abs[MAG_W-1:0];
        prr_next = PROD_W'(ar) * PROD_W'(ar);
        pii_next = PROD_W'(ai) * PROD_W'(ai);
        pri_next = PROD_W'(ar) * PROD_W'(ai);
        neg_next = zr_reg[Z_W-1] ^ zi_reg[Z_W-1];
    end

    // Escape test on the current z, and the next z from its products
    always_comb
    begin
        mag_sq    = SUM_W'(prr_reg) + SUM_W'(pii_reg);
        in_bounds = !big_reg && (mag_sq < SUM_W'(cfg.radius_sq));

        qr         = prr_reg[PROD_W-1:FRAC_BITS];
        qi         = pii_reg[PROD_W-1:FRAC_BITS];
        qx         = pri_reg[PROD_W-1:FRAC_BITS-1];
        qx_ext     = ACC_W'(qx);
        cross_term = neg_reg ? (~qx_ext + 1'b1) : qx_ext;
        acc_r  = {{(ACC_W-C_WIDTH){cr_reg[C_WIDTH-1]}}, cr_reg} + ACC_W'(qr) - ACC_W'(qi);
        acc_i  = {{(ACC_W-C_WIDTH){ci_reg[C_WIDTH-1]}}, ci_reg} + cross_term;
        zr_new = sat_z(acc_r);
        zi_new = sat_z(acc_i);

        keep_going = first_reg || (in_bounds && (count_reg < cfg.max_iter));
        out_free   = !out_valid_reg || m_tready;
    end

    // Sequencer: pop, multiply, accumulate, deliver
    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        big_next       = big_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_count_next = out_count_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        count_next     = count_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cr_next    = pop_data.c_real;
                    ci_next    = pop_data.c_imag;
                    zr_next    = '0;
                    zi_next    = '0;
                    big_next   = 1'b0;
                    first_next = 1'b1;
                    count_next = COUNT_WIDTH'(1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (keep_going)
                begin
                    count_next = count_reg + 1'b1;
                    zr_next    = zr_new;
                    zi_next    = zi_new;
                    big_next   = (zr_new > MAG_MAX) || (zr_new < -MAG_MAX)
                              || (zi_new > MAG_MAX) || (zi_new < -MAG_MAX);
                    first_next = 1'b0;
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            big_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            big_reg       <= big_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture products only in the multiply step
    always_ff @(posedge clk)
    begin
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
        if (state_reg == ST_MUL)
        begin
            prr_reg <= prr_next;
            pii_reg <= pii_next;
            pri_reg <= pri_next;
            neg_reg <= neg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;

endmodule

>>> rtl/core/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time counter.
`timescale 1ns / 1ps

// Each point c (signed Q4.28 on s_tdata) is iterated as z = z^2 + c from z = 0 until
// |z|^2 reaches the squared escape radius or the count reaches max_iterations; the
// count, at least 2, comes out on m_tdata. Each iteration in the back end is a
// multiply step forming zr^2, zi^2 and zr*zi, then an accumulate step that tests
// the escape condition and forms the next z. The engine pops a point, then runs a
// multiply and an accumulate step per count value; the default limit is 256.
// A two-entry queue lets the input side take new points while the engine runs,
// and the result register lets the engine go on while a result waits to be taken.
// Configuration writes are taken every cycle and belong only in idle periods.

module mandelbrot_escape_time
    import mbet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*C_WIDTH-1:0]   s_tdata,    // c_real [31:0], c_imag [63:32]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COUNT_WIDTH-1:0] m_tdata,    // iteration_count [15:0]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    q_status_t q_status;
    logic      push;
    point_t    push_data;
    logic      pop;
    point_t    pop_data;
    cfg_t      cfg;

    // Accept points and configuration
    mbet_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data),
        .cfg       (cfg)
    );

    // Decouple front and back
    mbet_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Iterate and deliver counts
    mbet_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop      (pop),
        .pop_data (pop_data),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/core/mbet_checker.sv
// Port-level checks for the escape-time counter, bound to the top level.
`timescale 1ns / 1ps

module mbet_checker
    import mbet_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [COUNT_WIDTH-1:0] m_tdata
);

    // A count never falls below the first completed step
    a_count_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= COUNT_WIDTH'(2)))
        else $error("iteration count below 2");

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // No result leaves on the first edge out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid straight out of reset");

    // The queue is empty out of reset, so the input side is open
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> s_tready)
        else $error("input not ready straight out of reset");

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
